// File: sv/fan_step_table_hysteresis_defines.svh
// ----------------------------------------------------------------------------
// Fan step table assertion macros
// Shared same-cycle and next-cycle implication checks, clocked on clk with
// the asynchronous reset disabling them.
// ----------------------------------------------------------------------------
`ifndef FAN_STEP_TABLE_HYSTERESIS_DEFINES_SVH
`define FAN_STEP_TABLE_HYSTERESIS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FST_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FST_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fst_pkg.sv
// ----------------------------------------------------------------------------
// Fan step table package
// Widths, the temperature bundle and the walk direction shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package fst_pkg;

	localparam int TEMP_W          = 8;
	localparam int RPM_W           = 16;
	localparam int LVL_W           = 3;
	localparam int WALK_W          = LVL_W + 1;
	localparam int WORD_W          = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int DEF_LEVEL_COUNT = 8;

	localparam int RPM_LSB = 48;

	typedef struct packed {
		logic signed [TEMP_W-1:0] cpu;
		logic signed [TEMP_W-1:0] vreg;
		logic signed [TEMP_W-1:0] chg;
	} temps_t;

	typedef enum logic [1:0] {
		DIR_HOLD,
		DIR_DOWN,
		DIR_UP
	} dir_t;

endpackage

`default_nettype wire

// File: sv/fan_step_table_hysteresis.sv
// ----------------------------------------------------------------------------
// Fan step table with hysteresis
// Walks a fan level up or down one table entry per cycle from three
// temperatures and emits the RPM target of the level it settles on.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | cpu_temp, regulator_temp, charger_temp
//  out      | out_valid / out_ready  | fan_rpm, fan_level
//  cfg      | cfg_wr_en              | cfg_index, cfg_data
//
// A result is registered once its transfer is accepted and walked: the
// sequencer steps level by level through the shared comparator, stops, and
// then reads the RPM into the output register before it is idle again, so a
// new transfer is not taken while one is walked. in_ready is high only
// while idle. A finished result waits in the output register while the
// next transfer is walked; the sequencer stalls in its last state only while
// that earlier result has still not been taken.
// Reset clears the level, the previous temperatures and the level table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fan_step_table_hysteresis_defines.svh"

module fan_step_table_hysteresis #(
	parameter int LEVEL_COUNT = fst_pkg::DEF_LEVEL_COUNT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [fst_pkg::TEMP_W-1:0]    cpu_temp,
	input  wire logic signed [fst_pkg::TEMP_W-1:0]    regulator_temp,
	input  wire logic signed [fst_pkg::TEMP_W-1:0]    charger_temp,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic             [fst_pkg::RPM_W-1:0]     fan_rpm,
	output logic             [fst_pkg::LVL_W-1:0]     fan_level,
	input  wire logic                                 cfg_wr_en,
	input  wire logic        [fst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [fst_pkg::WORD_W-1:0]    cfg_data
);

	localparam int WALK_W = fst_pkg::WALK_W;
	localparam logic [WALK_W-1:0] LVL_END = WALK_W'(LEVEL_COUNT);
	localparam logic [WALK_W-1:0] LVL_TOP = WALK_W'(LEVEL_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t                        state_q;
	fst_pkg::temps_t               temps_q;
	fst_pkg::temps_t               prev_q;
	fst_pkg::temps_t               in_temps;
	fst_pkg::dir_t                 dir_q;
	fst_pkg::dir_t                 dir_d;
	logic [WALK_W-1:0]             lvl_q;
	logic [WALK_W-1:0]             lvl_clamp;
	logic [fst_pkg::LVL_W-1:0]     level_now_q;
	logic                          out_valid_q;
	logic [fst_pkg::RPM_W-1:0]     rpm_q;
	logic [fst_pkg::LVL_W-1:0]     fan_q;
	logic [fst_pkg::WORD_W-1:0]    rd_word;
	logic                          cmp_step;
	logic                          step_ok;
	logic                          fell;
	logic                          rose;

	assign in_temps.cpu  = cpu_temp;
	assign in_temps.vreg = regulator_temp;
	assign in_temps.chg  = charger_temp;

	assign fell = (in_temps.cpu < prev_q.cpu) || (in_temps.vreg < prev_q.vreg) ||
		(in_temps.chg < prev_q.chg);
	assign rose = (in_temps.cpu > prev_q.cpu) || (in_temps.vreg > prev_q.vreg) ||
		(in_temps.chg > prev_q.chg);

	// A fall anywhere takes precedence over a rise elsewhere.
	always_comb begin
		priority if (fell) begin
			dir_d = fst_pkg::DIR_DOWN;
		end else if (rose) begin
			dir_d = fst_pkg::DIR_UP;
		end else begin
			dir_d = fst_pkg::DIR_HOLD;
		end
	end

	fst_regs #(
		.LEVEL_COUNT (LEVEL_COUNT)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_wr_en),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.rd_idx  (lvl_q[fst_pkg::LVL_W-1:0]),
		.rd_word (rd_word)
	);

	fst_cmp u_cmp (
		.temps (temps_q),
		.dir   (dir_q),
		.word  (rd_word),
		.step  (cmp_step)
	);

	always_comb begin
		unique case (dir_q)
			fst_pkg::DIR_DOWN: step_ok = (lvl_q != '0) && cmp_step;
			fst_pkg::DIR_UP:   step_ok = (lvl_q < LVL_END) && cmp_step;
			default:           step_ok = 1'b0;
		endcase
	end

	// A rising walk may run one past the last level.
	assign lvl_clamp = (lvl_q >= LVL_END) ? LVL_TOP : lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			temps_q     <= '0;
			prev_q      <= '0;
			dir_q       <= fst_pkg::DIR_HOLD;
			lvl_q       <= '0;
			level_now_q <= '0;
			out_valid_q <= 1'b0;
			rpm_q       <= '0;
			fan_q       <= '0;
		end else begin
			// In the final state the output register is refilled below instead.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						temps_q <= in_temps;
						prev_q  <= in_temps;
						dir_q   <= dir_d;
						lvl_q   <= {1'b0, level_now_q};
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (step_ok) begin
						if (dir_q == fst_pkg::DIR_UP) begin
							lvl_q <= lvl_q + WALK_W'(1);
						end else begin
							lvl_q <= lvl_q - WALK_W'(1);
						end
					end else begin
						lvl_q       <= lvl_clamp;
						level_now_q <= lvl_clamp[fst_pkg::LVL_W-1:0];
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						rpm_q       <= rd_word[fst_pkg::RPM_LSB +: fst_pkg::RPM_W];
						fan_q       <= lvl_q[fst_pkg::LVL_W-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign fan_rpm    = rpm_q;
	assign fan_level  = fan_q;

	`FST_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "block took a second transfer while walking")
	`FST_ASSERT_IMP(a_level_in_table, out_valid, int'(fan_level) < LEVEL_COUNT, "fan level beyond the table")
	`FST_ASSERT_IMP(a_done_level_kept, state_q == ST_DONE, lvl_q == {1'b0, level_now_q}, "settled level not recorded")
	`FST_ASSERT_NXT(a_hold_no_walk, state_q == ST_WALK && dir_q == fst_pkg::DIR_HOLD, state_q == ST_DONE && lvl_q == $past(lvl_q), "level moved with unchanged temperatures")

endmodule

`default_nettype wire

// File: sv/fst_regs.sv
// ----------------------------------------------------------------------------
// Fan step table level registers
// One 64-bit word per level, written through the configuration port and read
// at one address chosen by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_regs #(
	parameter int LEVEL_COUNT = fst_pkg::DEF_LEVEL_COUNT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [fst_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  wire logic [fst_pkg::WORD_W-1:0]     wr_data,
	input  wire logic [fst_pkg::LVL_W-1:0]      rd_idx,
	output logic      [fst_pkg::WORD_W-1:0]     rd_word
);

	localparam int IDX_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

	logic [fst_pkg::WORD_W-1:0] word_q [LEVEL_COUNT];

	// Words for levels the table does not cover are never consulted, so they
	// are not stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVEL_COUNT; i++) begin
				word_q[i] <= '0;
			end
		end else if (wr_en && (int'(wr_idx) < LEVEL_COUNT)) begin
			word_q[wr_idx[IDX_W-1:0]] <= wr_data;
		end
	end

	always_comb begin
		if (int'(rd_idx) < LEVEL_COUNT) begin
			rd_word = word_q[rd_idx[IDX_W-1:0]];
		end else begin
			rd_word = '0;
		end
	end

endmodule

`default_nettype wire

// File: sv/fst_cmp.sv
// ----------------------------------------------------------------------------
// Fan step table threshold comparator
// Shared compare unit: decides whether the level may take one more step in
// the current direction, against the thresholds of the word being read.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_cmp (
	input  wire fst_pkg::temps_t              temps,
	input  wire fst_pkg::dir_t                dir,
	input  wire logic [fst_pkg::WORD_W-1:0]   word,
	output logic                              step
);

	logic signed [fst_pkg::TEMP_W-1:0] on_cpu;
	logic signed [fst_pkg::TEMP_W-1:0] on_vreg;
	logic signed [fst_pkg::TEMP_W-1:0] on_chg;
	logic signed [fst_pkg::TEMP_W-1:0] off_cpu;
	logic signed [fst_pkg::TEMP_W-1:0] off_vreg;
	logic signed [fst_pkg::TEMP_W-1:0] off_chg;

	assign on_cpu   = $signed(word[7:0]);
	assign on_vreg  = $signed(word[15:8]);
	assign on_chg   = $signed(word[23:16]);
	assign off_cpu  = $signed(word[31:24]);
	assign off_vreg = $signed(word[39:32]);
	assign off_chg  = $signed(word[47:40]);

	always_comb begin
		unique case (dir)
			fst_pkg::DIR_DOWN: begin
				step = (temps.cpu < off_cpu) && (temps.vreg < off_vreg) &&
					(temps.chg < off_chg);
			end
			fst_pkg::DIR_UP: begin
				// The CPU alone may push the fan up; the other two only together.
				step = (temps.cpu > on_cpu) ||
					((temps.vreg > on_vreg) && (temps.chg > on_chg));
			end
			default: begin
				step = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire
